[design/smbios3_table_validator_assert.svh]
// Assertion macros shared by the checker of the SMBIOS 3.0 table validator.
// Each macro expects signals named clock and reset in the scope where it is used.
`ifndef SMBIOS3_TABLE_VALIDATOR_ASSERT_SVH
`define SMBIOS3_TABLE_VALIDATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define S3TV_ASSERT_NOW(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define S3TV_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[design/s3tv_pkg.sv]
// Package for the SMBIOS 3.0 table validator: widths, register indexes,
// entry point field positions and the anchor text. No dependencies.
`timescale 1ns / 1ps

package s3tv_pkg;

   // Bits of the table length that are kept; the byte counter has one more.
   localparam int LENGTH_BITS = 32;
   localparam int COUNT_BITS  = LENGTH_BITS + 1;

   // Configuration port
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 64;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_LENGTH  = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_TABLE_ADDRESS = 1'd1;

   // Entry point layout
   localparam logic [4:0] ANCHOR_COUNT_MAX = 5'd31;
   localparam logic [4:0] ENTRY_LEN        = 5'd24;
   localparam logic [7:0] ENTRY_LEN_BYTE   = 8'd24;
   localparam logic [7:0] SPEC_MAJOR       = 8'd3;
   localparam logic [7:0] ENTRY_REVISION   = 8'd1;
   localparam logic [4:0] POS_ANCHOR_LAST  = 5'd4;
   localparam logic [4:0] POS_CHECKSUM     = 5'd5;
   localparam logic [4:0] POS_LENGTH       = 5'd6;
   localparam logic [4:0] POS_MAJOR        = 5'd7;
   localparam logic [4:0] POS_MINOR        = 5'd8;
   localparam logic [4:0] POS_DOCREV       = 5'd9;
   localparam logic [4:0] POS_REVISION     = 5'd10;
   localparam logic [4:0] POS_RESERVED     = 5'd11;
   localparam logic [4:0] POS_MAX_SIZE     = 5'd12;
   localparam logic [4:0] POS_MAX_SIZE_END = 5'd15;
   localparam logic [4:0] POS_ADDRESS      = 5'd16;
   localparam logic [4:0] POS_ADDRESS_END  = 5'd23;

   // Structure header
   localparam logic [7:0] HDR_POS_TYPE = 8'd0;
   localparam logic [7:0] HDR_POS_LEN  = 8'd1;
   localparam logic [7:0] HDR_POS_BODY = 8'd3;
   localparam logic [7:0] HDR_MIN_LEN  = 8'd4;
   localparam logic [7:0] END_TYPE     = 8'd127;

   // Characters of "_SM3_" by position.
   function automatic logic [7:0] anchor_char(input logic [2:0] pos);
      logic [7:0] ch;
      case (pos)
         3'd0:    ch = 8'h5F;
         3'd1:    ch = 8'h53;
         3'd2:    ch = 8'h4D;
         3'd3:    ch = 8'h33;
         3'd4:    ch = 8'h5F;
         default: ch = 8'h00;
      endcase
      return ch;
   endfunction

endpackage

[design/smbios3_table_validator.sv]
// SMBIOS 3.0 entry point and structure table validator, top level.
// Depends on s3tv_pkg.
`timescale 1ns / 1ps
//
//  Channel   Direction  Handshake                 Payload
//  req_      in         req_valid / req_stall     req_data_byte, req_is_anchor, req_last
//  rsp_      out        rsp_valid / rsp_stall     rsp_valid_res
//  csr_      in         csr_valid / csr_ready     csr_index, csr_data
//
//  One byte per cycle unless req_stall holds it: each accepted item updates the
//  walk state in the same cycle, and the verdict of a last item sits in the
//  result register on the following cycle.
//  Reset is synchronous and clears the walk state, the result valid flag and
//  both configuration registers; the verdict bit itself is not reset.
//  A stalled result holds the input only for a last item; all other bytes keep
//  flowing past it.

module smbios3_table_validator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [7:0]                          req_data_byte,
   input  logic                                req_is_anchor,
   input  logic                                req_last,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic                                rsp_valid_res,
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [s3tv_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [s3tv_pkg::CSR_DATA_BITS-1:0]  csr_data
);
   import s3tv_pkg::*;

   // Configuration
   logic [LENGTH_BITS-1:0]   table_length_ff;
   logic [63:0]              table_address_ff;

   // Entry point state
   logic [4:0]               anchor_count_ff, anchor_count_in;
   logic [7:0]               anchor_sum_ff, anchor_sum_in;
   logic                     anchor_good_ff, anchor_good_in;

   // Table walk state
   logic [COUNT_BITS-1:0]    table_count_ff, table_count_in;
   logic [7:0]               header_pos_ff, header_pos_in;
   logic [7:0]               header_len_ff, header_len_in;
   logic [7:0]               header_type_ff, header_type_in;
   logic                     in_strings_ff, in_strings_in;
   logic                     prev_zero_ff, prev_zero_in;
   logic                     end_seen_ff, end_seen_in;
   logic                     table_good_ff, table_good_in;

   // Result register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_res_ff, rsp_res_in;

   logic                     accept;
   logic                     anchor_ok;
   logic                     verdict;
   logic [31:0]              length_bytes;
   logic [COUNT_BITS-1:0]    length_ext;
   logic [COUNT_BITS-1:0]    remaining;
   logic                     count_at_end;

   // Hold a last item back only while the result register cannot take it.
   assign req_stall = rsp_valid_ff && rsp_stall && req_last;
   assign accept    = req_valid && !req_stall;
   assign csr_ready = 1'b1;

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_valid_res = rsp_res_ff;

   // Expected length as a 32-bit field of the entry point and as a count.
   assign length_bytes = 32'(table_length_ff);
   assign length_ext   = COUNT_BITS'(table_length_ff);
   assign count_at_end = (table_count_ff >= length_ext);
   assign remaining    = length_ext - table_count_ff;

   // Check one entry point byte against its field.
   always_comb begin
      anchor_ok = 1'b0;
      case (anchor_count_ff) inside
         [5'd0:POS_ANCHOR_LAST]:
            anchor_ok = (req_data_byte == anchor_char(anchor_count_ff[2:0]));
         POS_CHECKSUM:
            anchor_ok = 1'b1;
         POS_LENGTH:
            anchor_ok = (req_data_byte == ENTRY_LEN_BYTE);
         POS_MAJOR:
            anchor_ok = (req_data_byte == SPEC_MAJOR);
         POS_MINOR, POS_DOCREV, POS_RESERVED:
            anchor_ok = (req_data_byte == 8'd0);
         POS_REVISION:
            anchor_ok = (req_data_byte == ENTRY_REVISION);
         [POS_MAX_SIZE:POS_MAX_SIZE_END]:
            anchor_ok = (req_data_byte == length_bytes[{anchor_count_ff[1:0], 3'b000} +: 8]);
         [POS_ADDRESS:POS_ADDRESS_END]:
            anchor_ok = (req_data_byte ==
                         table_address_ff[{anchor_count_ff[2:0], 3'b000} +: 8]);
         default:
            anchor_ok = 1'b0;
      endcase
   end

   // Advance the walk by one byte and form the verdict.
   always_comb begin
      anchor_count_in = anchor_count_ff;
      anchor_sum_in   = anchor_sum_ff;
      anchor_good_in  = anchor_good_ff;
      table_count_in  = table_count_ff;
      header_pos_in   = header_pos_ff;
      header_len_in   = header_len_ff;
      header_type_in  = header_type_ff;
      in_strings_in   = in_strings_ff;
      prev_zero_in    = prev_zero_ff;
      end_seen_in     = end_seen_ff;
      table_good_in   = table_good_ff;
      verdict         = 1'b0;

      if (accept) begin
         if (req_is_anchor) begin
            // An entry point byte after any table byte spoils the entry point.
            if (table_count_ff != '0) begin
               anchor_good_in = 1'b0;
            end
            if (!anchor_ok) begin
               anchor_good_in = 1'b0;
            end
            anchor_sum_in = anchor_sum_ff + req_data_byte;
            if (anchor_count_ff != ANCHOR_COUNT_MAX) begin
               anchor_count_in = anchor_count_ff + 5'd1;
            end
         end else begin
            // Drop the walk on overrun or on bytes after the end structure.
            if (count_at_end || end_seen_ff) begin
               table_good_in = 1'b0;
            end
            if (table_good_in) begin
               if (!in_strings_ff) begin
                  if (header_pos_ff == HDR_POS_TYPE) begin
                     if (remaining < COUNT_BITS'(HDR_MIN_LEN)) begin
                        table_good_in = 1'b0;
                     end
                     header_type_in = req_data_byte;
                  end else if (header_pos_ff == HDR_POS_LEN) begin
                     header_len_in = req_data_byte;
                     if (req_data_byte < HDR_MIN_LEN) begin
                        table_good_in = 1'b0;
                     end
                  end
                  header_pos_in = header_pos_ff + 8'd1;
                  // Last formatted byte: move on to the string set.
                  if (header_pos_ff >= HDR_POS_BODY &&
                      (header_pos_ff + 8'd1) == header_len_ff) begin
                     in_strings_in = 1'b1;
                     prev_zero_in  = 1'b0;
                     header_pos_in = 8'd0;
                  end
               end else if (req_data_byte == 8'd0 && prev_zero_ff) begin
                  // Double zero closes the structure.
                  in_strings_in = 1'b0;
                  prev_zero_in  = 1'b0;
                  header_pos_in = 8'd0;
                  if (header_type_ff == END_TYPE) begin
                     end_seen_in = 1'b1;
                  end
               end else begin
                  prev_zero_in = (req_data_byte == 8'd0);
               end
            end
            if (table_count_ff != '1) begin
               table_count_in = table_count_ff + COUNT_BITS'(1);
            end
         end

         verdict = anchor_good_in && (anchor_count_in == ENTRY_LEN) &&
                   (anchor_sum_in == 8'd0) && table_good_in && end_seen_in &&
                   (table_count_in == length_ext);

         // Return to the start-of-stream state after the final byte.
         if (req_last) begin
            anchor_count_in = '0;
            anchor_sum_in   = '0;
            anchor_good_in  = 1'b1;
            table_count_in  = '0;
            header_pos_in   = '0;
            header_len_in   = '0;
            header_type_in  = '0;
            in_strings_in   = 1'b0;
            prev_zero_in    = 1'b0;
            end_seen_in     = 1'b0;
            table_good_in   = 1'b1;
         end
      end
   end

   // Load a verdict on a last item, else drain once taken.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (accept && req_last) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = verdict;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         table_length_ff  <= '0;
         table_address_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_TABLE_LENGTH:  table_length_ff  <= csr_data[LENGTH_BITS-1:0];
            CSR_TABLE_ADDRESS: table_address_ff <= csr_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_count_ff <= '0;
         anchor_sum_ff   <= '0;
         anchor_good_ff  <= 1'b1;
         table_count_ff  <= '0;
         header_pos_ff   <= '0;
         header_len_ff   <= '0;
         header_type_ff  <= '0;
         in_strings_ff   <= 1'b0;
         prev_zero_ff    <= 1'b0;
         end_seen_ff     <= 1'b0;
         table_good_ff   <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         anchor_count_ff <= anchor_count_in;
         anchor_sum_ff   <= anchor_sum_in;
         anchor_good_ff  <= anchor_good_in;
         table_count_ff  <= table_count_in;
         header_pos_ff   <= header_pos_in;
         header_len_ff   <= header_len_in;
         header_type_ff  <= header_type_in;
         in_strings_ff   <= in_strings_in;
         prev_zero_ff    <= prev_zero_in;
         end_seen_ff     <= end_seen_in;
         table_good_ff   <= table_good_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

endmodule

[design/s3tv_checker.sv]
// Port-level checker for the SMBIOS 3.0 table validator, bound to the top level.
// Depends on smbios3_table_validator_assert.svh.
`timescale 1ns / 1ps
`include "smbios3_table_validator_assert.svh"

module s3tv_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_last,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_valid_res
);

   // A stalled verdict holds.
   `S3TV_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_valid_res), "verdict changed while stalled")

   // A fresh verdict follows an accepted final byte.
   `S3TV_ASSERT_NOW(a_rsp_cause, rsp_valid && !$past(rsp_valid && rsp_stall), $past(req_valid && !req_stall && req_last), "verdict without a final byte")

   // A byte that is not the final one never raises a verdict.
   `S3TV_ASSERT_NEXT(a_no_early_rsp, req_valid && !req_stall && !req_last && !(rsp_valid && rsp_stall), !rsp_valid, "verdict raised by an inner byte")

   // The input stalls only behind a blocked verdict.
   `S3TV_ASSERT_NOW(a_stall_cause, req_stall, rsp_valid && rsp_stall && req_last, "input stalled with the output free")

endmodule

bind smbios3_table_validator s3tv_checker u_s3tv_checker (.*);
